>>> design/halfblock_truecolor_ansi_encoder_assert.svh
// Assertion macros shared by the encoder modules.
// They expect signals named clk and rst_n in the module that uses them.
`ifndef HALFBLOCK_TRUECOLOR_ANSI_ENCODER_ASSERT_SVH
`define HALFBLOCK_TRUECOLOR_ANSI_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTAE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/htae_pkg.sv
`default_nettype none

package htae_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [7:0] LAST_RESET = 8'd255;

    typedef enum logic [1:0] {
        ACT_PALETTE = 2'd0,
        ACT_START   = 2'd1,
        ACT_CELL    = 2'd2,
        ACT_END     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_HOME,
        KIND_CELL,
        KIND_END
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HOME,
        PH_END,
        PH_PREFIX,
        PH_COMP,
        PH_SEP,
        PH_GLYPH
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic        bg;
        logic        fg;
        logic [23:0] bg_rgb;
        logic [23:0] fg_rgb;
    } cmd_t;

    function automatic logic [7:0] home_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h1b;
            2'd1:    b = 8'h5b;
            default: b = 8'h48;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] end_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h1b;
            2'd1:    b = 8'h5b;
            2'd2:    b = 8'h30;
            default: b = 8'h6d;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] glyph_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'he2;
            2'd1:    b = 8'h96;
            default: b = 8'h84;
        endcase
        return b;
    endfunction

    // The third byte selects background (4) or foreground (3).
    function automatic logic [7:0] prefix_byte(input logic [2:0] idx, input logic fg);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h1b;
            3'd1:    b = 8'h5b;
            3'd2:    b = fg ? 8'h33 : 8'h34;
            3'd3:    b = 8'h38;
            3'd4:    b = 8'h3b;
            3'd5:    b = 8'h32;
            default: b = 8'h3b;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] comp_value(input logic [23:0] rgb, input logic [1:0] comp);
        logic [7:0] v;
        case (comp)
            2'd0:    v = rgb[23:16];
            2'd1:    v = rgb[15:8];
            default: v = rgb[7:0];
        endcase
        return v;
    endfunction

    // Returns hundreds, tens and ones digits as {h, t, o}.
    function automatic logic [11:0] dec_digits(input logic [7:0] v);
        logic [3:0]  h;
        logic [3:0]  t;
        logic [3:0]  o;
        logic [7:0]  r;
        logic [14:0] m;
        logic [7:0]  tens;
        if (v >= 8'd200) begin
            h = 4'd2;
            r = v - 8'd200;
        end else if (v >= 8'd100) begin
            h = 4'd1;
            r = v - 8'd100;
        end else begin
            h = 4'd0;
            r = v;
        end
        m = 15'(r) * 15'd205;
        t = m[14:11];
        tens = 8'(t) * 8'd10;
        o = 4'(r - tens);
        return {h, t, o};
    endfunction

    // Position of the first digit written, so that no leading zero appears.
    function automatic logic [2:0] first_digit(input logic [7:0] v);
        logic [2:0] p;
        if (v >= 8'd100) begin
            p = 3'd0;
        end else if (v >= 8'd10) begin
            p = 3'd1;
        end else begin
            p = 3'd2;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> design/htae_ram.sv
`default_nettype none

module htae_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> design/htae_queue.sv
`default_nettype none
`include "halfblock_truecolor_ansi_encoder_assert.svh"

module htae_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire htae_pkg::cmd_t din,
    output logic               full,
    input  wire logic          pop,
    output htae_pkg::cmd_t     dout,
    output logic               empty
);

    localparam int QD = htae_pkg::QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    htae_pkg::cmd_t mem_reg [QD];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full = (count_reg == CW'(QD));
    assign empty = (count_reg == '0);
    assign dout = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    `HTAE_ASSERT_IMPL(a_no_push_when_full, push, !full, "queue pushed while full")
    `HTAE_ASSERT_NEXT(a_push_fills, do_push && !do_pop, !empty, "queue empty after a push")

endmodule

`default_nettype wire

>>> design/htae_front.sv
`default_nettype none
`include "halfblock_truecolor_ansi_encoder_assert.svh"

module htae_front #(
    parameter int PALETTE_DEPTH = htae_pkg::PALETTE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [1:0]    action,
    input  wire logic [7:0]    top_index,
    input  wire logic [7:0]    bottom_index,
    input  wire logic [23:0]   palette_rgb,
    input  wire logic          q_full,
    output logic               q_push,
    output htae_pkg::cmd_t     q_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic            accept;
    logic            top_ok;
    logic            bottom_ok;
    logic            ram_we;
    logic            ram_re;
    logic [23:0]     rdata_top;
    logic [23:0]     rdata_bottom;

    logic [7:0]      last_top_reg;
    logic [7:0]      last_top_next;
    logic [7:0]      last_bottom_reg;
    logic [7:0]      last_bottom_next;
    logic            s1_valid_reg;
    logic            s1_valid_next;
    htae_pkg::kind_t s1_kind_reg;
    htae_pkg::kind_t s1_kind_next;
    logic            s1_bg_reg;
    logic            s1_bg_next;
    logic            s1_fg_reg;
    logic            s1_fg_next;
    logic            s1_top_ok_reg;
    logic            s1_bottom_ok_reg;

    assign full = s1_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = s1_valid_reg && !q_full;
    assign top_ok = ({1'b0, top_index} < 9'(PALETTE_DEPTH));
    assign bottom_ok = ({1'b0, bottom_index} < 9'(PALETTE_DEPTH));
    assign ram_we = accept && (action == htae_pkg::ACT_PALETTE) && top_ok;
    assign ram_re = accept && (action == htae_pkg::ACT_CELL);

    htae_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (top_index[AW-1:0]),
        .wdata   (palette_rgb),
        .re      (ram_re),
        .raddr_a (top_index[AW-1:0]),
        .raddr_b (bottom_index[AW-1:0]),
        .rdata_a (rdata_top),
        .rdata_b (rdata_bottom)
    );

    always_comb
    begin
        last_top_next = last_top_reg;
        last_bottom_next = last_bottom_reg;
        s1_valid_next = q_push ? 1'b0 : s1_valid_reg;
        s1_kind_next = s1_kind_reg;
        s1_bg_next = s1_bg_reg;
        s1_fg_next = s1_fg_reg;
        if (accept)
        begin
            case (action)
                htae_pkg::ACT_START:
                begin
                    last_top_next = htae_pkg::LAST_RESET;
                    last_bottom_next = htae_pkg::LAST_RESET;
                    s1_valid_next = 1'b1;
                    s1_kind_next = htae_pkg::KIND_HOME;
                end
                htae_pkg::ACT_CELL:
                begin
                    last_top_next = top_index;
                    last_bottom_next = bottom_index;
                    s1_valid_next = 1'b1;
                    s1_kind_next = htae_pkg::KIND_CELL;
                    s1_bg_next = (top_index != last_top_reg);
                    s1_fg_next = (bottom_index != last_bottom_reg);
                end
                htae_pkg::ACT_END:
                begin
                    s1_valid_next = 1'b1;
                    s1_kind_next = htae_pkg::KIND_END;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_top_reg <= htae_pkg::LAST_RESET;
            last_bottom_reg <= htae_pkg::LAST_RESET;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            last_top_reg <= last_top_next;
            last_bottom_reg <= last_bottom_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= s1_kind_next;
        s1_bg_reg <= s1_bg_next;
        s1_fg_reg <= s1_fg_next;
        if (ram_re)
        begin
            s1_top_ok_reg <= top_ok;
            s1_bottom_ok_reg <= bottom_ok;
        end
    end

    always_comb
    begin
        q_data.kind = s1_kind_reg;
        q_data.bg = s1_bg_reg;
        q_data.fg = s1_fg_reg;
        q_data.bg_rgb = s1_top_ok_reg ? rdata_top : 24'd0;
        q_data.fg_rgb = s1_bottom_ok_reg ? rdata_bottom : 24'd0;
    end

    `HTAE_ASSERT_NEXT(a_item_staged, accept && (action != htae_pkg::ACT_PALETTE),
        s1_valid_reg, "accepted item not staged")
    `HTAE_ASSERT_IMPL(a_full_only_staged, full, s1_valid_reg, "full without a staged item")

endmodule

`default_nettype wire

>>> design/htae_back.sv
`default_nettype none
`include "halfblock_truecolor_ansi_encoder_assert.svh"

module htae_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire htae_pkg::cmd_t q_data,
    output logic               q_pop,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         out_byte,
    output logic               last_of_run
);

    htae_pkg::phase_t phase_reg;
    htae_pkg::phase_t phase_next;
    logic [2:0]       cnt_reg;
    logic [2:0]       cnt_next;
    logic [1:0]       comp_reg;
    logic [1:0]       comp_next;
    logic             sel_reg;
    logic             sel_next;
    htae_pkg::cmd_t   cmd_reg;
    htae_pkg::cmd_t   cmd_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             last_reg;

    logic             advance;
    logic             emit;
    logic [23:0]      cur_rgb;
    logic [7:0]       cur_val;
    logic [7:0]       first_val;
    logic [7:0]       next_val;
    logic [11:0]      digits;
    logic [3:0]       digit;
    logic [7:0]       byte_now;
    logic             last_now;

    assign advance = !out_valid_reg || pop;
    assign emit = (phase_reg != htae_pkg::PH_IDLE);
    assign q_pop = (phase_reg == htae_pkg::PH_IDLE) && !q_empty;
    assign cur_rgb = sel_reg ? cmd_reg.fg_rgb : cmd_reg.bg_rgb;
    assign cur_val = htae_pkg::comp_value(cur_rgb, comp_reg);
    assign first_val = htae_pkg::comp_value(cur_rgb, 2'd0);
    assign next_val = htae_pkg::comp_value(cur_rgb, comp_reg + 2'd1);
    assign digits = htae_pkg::dec_digits(cur_val);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        comp_next = comp_reg;
        sel_next = sel_reg;
        cmd_next = cmd_reg;
        case (phase_reg)
            htae_pkg::PH_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next = q_data;
                    cnt_next = 3'd0;
                    comp_next = 2'd0;
                    sel_next = 1'b0;
                    case (q_data.kind)
                        htae_pkg::KIND_HOME: phase_next = htae_pkg::PH_HOME;
                        htae_pkg::KIND_END:  phase_next = htae_pkg::PH_END;
                        htae_pkg::KIND_CELL:
                        begin
                            if (q_data.bg)
                            begin
                                phase_next = htae_pkg::PH_PREFIX;
                            end
                            else if (q_data.fg)
                            begin
                                phase_next = htae_pkg::PH_PREFIX;
                                sel_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = htae_pkg::PH_GLYPH;
                            end
                        end
                        default: phase_next = htae_pkg::PH_IDLE;
                    endcase
                end
            end
            htae_pkg::PH_HOME, htae_pkg::PH_GLYPH:
            begin
                if (advance)
                begin
                    if (cnt_reg == 3'd2)
                    begin
                        phase_next = htae_pkg::PH_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            htae_pkg::PH_END:
            begin
                if (advance)
                begin
                    if (cnt_reg == 3'd3)
                    begin
                        phase_next = htae_pkg::PH_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            htae_pkg::PH_PREFIX:
            begin
                if (advance)
                begin
                    if (cnt_reg == 3'd6)
                    begin
                        phase_next = htae_pkg::PH_COMP;
                        comp_next = 2'd0;
                        cnt_next = htae_pkg::first_digit(first_val);
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            htae_pkg::PH_COMP:
            begin
                if (advance)
                begin
                    if (cnt_reg == 3'd2)
                    begin
                        phase_next = htae_pkg::PH_SEP;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            htae_pkg::PH_SEP:
            begin
                if (advance)
                begin
                    if (comp_reg != 2'd2)
                    begin
                        phase_next = htae_pkg::PH_COMP;
                        comp_next = comp_reg + 2'd1;
                        cnt_next = htae_pkg::first_digit(next_val);
                    end
                    else if (!sel_reg && cmd_reg.fg)
                    begin
                        phase_next = htae_pkg::PH_PREFIX;
                        sel_next = 1'b1;
                        cnt_next = 3'd0;
                    end
                    else
                    begin
                        phase_next = htae_pkg::PH_GLYPH;
                        cnt_next = 3'd0;
                    end
                end
            end
            default: phase_next = htae_pkg::PH_IDLE;
        endcase
    end

    always_comb
    begin
        byte_now = 8'h00;
        last_now = 1'b0;
        case (cnt_reg)
            3'd0:    digit = digits[11:8];
            3'd1:    digit = digits[7:4];
            default: digit = digits[3:0];
        endcase
        case (phase_reg)
            htae_pkg::PH_HOME:
            begin
                byte_now = htae_pkg::home_byte(cnt_reg[1:0]);
                last_now = (cnt_reg == 3'd2);
            end
            htae_pkg::PH_END:
            begin
                byte_now = htae_pkg::end_byte(cnt_reg[1:0]);
                last_now = (cnt_reg == 3'd3);
            end
            htae_pkg::PH_GLYPH:
            begin
                byte_now = htae_pkg::glyph_byte(cnt_reg[1:0]);
                last_now = (cnt_reg == 3'd2);
            end
            htae_pkg::PH_PREFIX: byte_now = htae_pkg::prefix_byte(cnt_reg, sel_reg);
            htae_pkg::PH_COMP:   byte_now = {4'h3, digit};
            htae_pkg::PH_SEP:    byte_now = (comp_reg == 2'd2) ? 8'h6d : 8'h3b;
            default:
            begin
                byte_now = 8'h00;
                last_now = 1'b0;
            end
        endcase
    end

    assign out_valid_next = advance ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= htae_pkg::PH_IDLE;
            cnt_reg <= 3'd0;
            comp_reg <= 2'd0;
            sel_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            comp_reg <= comp_next;
            sel_reg <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (advance && emit)
        begin
            out_byte_reg <= byte_now;
            last_reg <= last_now;
        end
    end

    assign empty = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign last_of_run = last_reg;

    `HTAE_ASSERT_NEXT(a_last_ends_run, advance && emit && last_now,
        phase_reg == htae_pkg::PH_IDLE, "sequencer kept running after the last byte")
    `HTAE_ASSERT_IMPL(a_comp_range, phase_reg == htae_pkg::PH_COMP || phase_reg == htae_pkg::PH_SEP,
        comp_reg != 2'd3, "color component out of range")

endmodule

`default_nettype wire

>>> design/halfblock_truecolor_ansi_encoder.sv
// Channel   Handshake          Payload
// input     push / full        action, top_index, bottom_index, palette_rgb
// result    empty / pop        out_byte, last_of_run
//
// A palette write yields no result. Other items pass a staging register and a
// two-entry command queue to the byte sequencer, which takes a command while
// idle and then emits one byte per cycle while pop does not stall it: 3 bytes
// for a frame start, 4 for a frame end, 3 to 41 for a cell.
// Reset is asynchronous; the palette holds no defined value until written.
// A low pop with a byte waiting holds the output register and byte phases; the
// input side keeps taking items until the staging register and queue are full.
`default_nettype none

module halfblock_truecolor_ansi_encoder #(
    parameter int PALETTE_DEPTH = htae_pkg::PALETTE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  top_index,
    input  wire logic [7:0]  bottom_index,
    input  wire logic [23:0] palette_rgb,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             last_of_run
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    htae_pkg::cmd_t q_in;
    htae_pkg::cmd_t q_out;

    htae_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .top_index    (top_index),
        .bottom_index (bottom_index),
        .palette_rgb  (palette_rgb),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    htae_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    htae_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
